@@ rtl/assert_macros.svh @@
// assertion macros for the serial master rtl
// no dependencies; simulation builds leave SYNTH undefined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/tws_pkg.sv @@
// types and constants for the three-wire serial master
// no dependencies
`timescale 1ns / 1ps

package tws_pkg;

    localparam int CFG_W          = 10;
    localparam int BYTE_W         = 8;
    localparam int TX_W           = 16;
    localparam int BIT_CNT_W      = 5;
    localparam int DELAY_BITS_DEF = 10;

    localparam logic [CFG_W-1:0]     CFG_RESET  = 10'd8;
    localparam logic [1:0]           MODE_READ  = 2'd1;
    localparam logic [1:0]           MODE_WRITE = 2'd2;
    localparam logic [BIT_CNT_W-1:0] READ_BITS  = 5'd8;
    localparam logic [BIT_CNT_W-1:0] WRITE_BITS = 5'd16;

    typedef struct packed {
        logic              data_pin_in;
        logic [BYTE_W-1:0] write_byte;
        logic [BYTE_W-1:0] command_byte;
        logic [1:0]        mode;
    } tws_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic              done_res;
        logic              busy_res;
        logic              chip_enable_pin;
        logic              data_drive_enable;
        logic              data_pin_out;
        logic              clock_pin;
    } tws_result_t;

endpackage

@@ rtl/three_wire_serial_master_unit.sv @@
// three-wire serial bus master: top level with input and result registers
// depends on tws_pkg and tws_core
// path: an accepted request is held in the input register, and its result in the result register
// throughput: one request per cycle while the result is taken (m_tready); each request is one sequencer tick
// reset: asynchronous active low; idle, pins low with data driven, half period 8
`timescale 1ns / 1ps

module three_wire_serial_master_unit
    import tws_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // command_byte, write_byte, data_pin_in, zero pad
    input  logic [1:0]       s_tuser,   // mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata    // clock_pin, data_pin_out, data_drive_enable,
                                        // chip_enable_pin, busy_res, done_res,
                                        // read_byte, zero pad
);

    logic        in_valid_reg;
    tws_item_t   item_reg;
    logic        out_valid_reg;
    tws_result_t out_reg;
    tws_result_t result;
    logic        step_en;

    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    tws_core #(
        .DELAY_BITS (DELAY_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .item        (item_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.mode         <= s_tuser;
            item_reg.command_byte <= s_tdata[7:0];
            item_reg.write_byte   <= s_tdata[15:8];
            item_reg.data_pin_in  <= s_tdata[16];
        end
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

endmodule

@@ rtl/tws_core.sv @@
// pin sequencer state and one-tick update logic
// depends on tws_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tws_core
    import tws_pkg::*;
#(
    parameter int DELAY_BITS = DELAY_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             step_en,
    input  tws_item_t        item,
    output tws_result_t      result
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_LEAD    = 4'd1;
    localparam logic [3:0] PH_TX_LOW  = 4'd2;
    localparam logic [3:0] PH_TX_HIGH = 4'd3;
    localparam logic [3:0] PH_TURN    = 4'd4;
    localparam logic [3:0] PH_RX_LOW  = 4'd5;
    localparam logic [3:0] PH_RX_HIGH = 4'd6;
    localparam logic [3:0] PH_TAIL    = 4'd7;

    localparam int CW = (DELAY_BITS > CFG_W) ? DELAY_BITS : CFG_W;

    logic [CFG_W-1:0]      half_reg;
    logic [3:0]            phase_reg, phase_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [DELAY_BITS-1:0] dly_cnt_reg, dly_cnt_next;
    logic [TX_W-1:0]       tx_shift_reg, tx_shift_next;
    logic [BYTE_W-1:0]     rx_shift_reg, rx_shift_next;
    logic                  is_read_reg, is_read_next;
    logic                  clk_pin_reg, clk_pin_next;
    logic                  dout_reg, dout_next;
    logic                  drv_reg, drv_next;
    logic                  ce_reg, ce_next;
    logic                  done;

    logic [CW-1:0]         half_ext;
    logic [CW-1:0]         half_max;
    logic [CW-1:0]         half_sat;
    logic [DELAY_BITS-1:0] half_trunc;
    logic [DELAY_BITS-1:0] half_eff;
    logic [DELAY_BITS-1:0] dly_inc;
    logic [BIT_CNT_W-1:0]  bit_limit;

    // effective half period: saturated to the counter, zero acts as one
    assign half_ext   = CW'(half_reg);
    assign half_max   = CW'((1 << DELAY_BITS) - 1);
    assign half_sat   = (half_ext > half_max) ? half_max : half_ext;
    assign half_trunc = half_sat[DELAY_BITS-1:0];
    assign half_eff   = (half_trunc == '0) ? DELAY_BITS'(1) : half_trunc;
    assign dly_inc    = dly_cnt_reg + DELAY_BITS'(1);
    assign bit_limit  = is_read_reg ? READ_BITS : WRITE_BITS;

    always_comb
    begin
        phase_next    = phase_reg;
        bit_cnt_next  = bit_cnt_reg;
        dly_cnt_next  = dly_cnt_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        is_read_next  = is_read_reg;
        clk_pin_next  = clk_pin_reg;
        dout_next     = dout_reg;
        drv_next      = drv_reg;
        ce_next       = ce_reg;
        done          = 1'b0;
        if (step_en)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.mode == MODE_READ || item.mode == MODE_WRITE)
                begin
                    is_read_next  = (item.mode == MODE_READ);
                    tx_shift_next = {item.write_byte, item.command_byte};
                    if (item.mode == MODE_READ)
                    begin
                        rx_shift_next = '0;
                    end
                    bit_cnt_next  = '0;
                    dly_cnt_next  = '0;
                    clk_pin_next  = 1'b0;
                    dout_next     = 1'b0;
                    drv_next      = 1'b1;
                    ce_next       = 1'b1;
                    phase_next    = PH_LEAD;
                end
            end
            else if (dly_inc >= half_eff)
            begin
                dly_cnt_next = '0;
                case (phase_reg)
                    PH_LEAD, PH_TX_HIGH:
                    begin
                        if (phase_reg == PH_LEAD || bit_cnt_reg < bit_limit)
                        begin
                            // next bit out, lsb first
                            dout_next     = tx_shift_reg[0];
                            tx_shift_next = tx_shift_reg >> 1;
                            clk_pin_next  = 1'b0;
                            bit_cnt_next  = bit_cnt_reg + BIT_CNT_W'(1);
                            phase_next    = PH_TX_LOW;
                        end
                        else if (is_read_reg)
                        begin
                            drv_next   = 1'b0;
                            dout_next  = 1'b0;
                            phase_next = PH_TURN;
                        end
                        else
                        begin
                            clk_pin_next = 1'b0;
                            ce_next      = 1'b0;
                            phase_next   = PH_TAIL;
                        end
                    end
                    PH_TX_LOW:
                    begin
                        clk_pin_next = 1'b1;
                        phase_next   = PH_TX_HIGH;
                    end
                    PH_TURN:
                    begin
                        clk_pin_next = 1'b0;
                        bit_cnt_next = '0;
                        phase_next   = PH_RX_LOW;
                    end
                    PH_RX_LOW:
                    begin
                        // sample on the rising clock
                        clk_pin_next = 1'b1;
                        if (item.data_pin_in)
                        begin
                            rx_shift_next[bit_cnt_reg[2:0]] = 1'b1;
                        end
                        bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                        phase_next   = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        if (bit_cnt_reg < READ_BITS)
                        begin
                            clk_pin_next = 1'b0;
                            phase_next   = PH_RX_LOW;
                        end
                        else
                        begin
                            clk_pin_next = 1'b0;
                            ce_next      = 1'b0;
                            phase_next   = PH_TAIL;
                        end
                    end
                    PH_TAIL:
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                dly_cnt_next = dly_inc;
            end
        end
    end

    always_comb
    begin
        result.clock_pin         = clk_pin_next;
        result.data_pin_out      = drv_next & dout_next;
        result.data_drive_enable = drv_next;
        result.chip_enable_pin   = ce_next;
        result.busy_res          = (phase_next != PH_IDLE);
        result.done_res          = done;
        result.read_byte         = rx_shift_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg     <= CFG_RESET;
            phase_reg    <= PH_IDLE;
            bit_cnt_reg  <= '0;
            dly_cnt_reg  <= '0;
            tx_shift_reg <= '0;
            rx_shift_reg <= '0;
            is_read_reg  <= 1'b0;
            clk_pin_reg  <= 1'b0;
            dout_reg     <= 1'b0;
            drv_reg      <= 1'b1;
            ce_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                half_reg <= cfg_wr_data;
            end
            phase_reg    <= phase_next;
            bit_cnt_reg  <= bit_cnt_next;
            dly_cnt_reg  <= dly_cnt_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            is_read_reg  <= is_read_next;
            clk_pin_reg  <= clk_pin_next;
            dout_reg     <= dout_next;
            drv_reg      <= drv_next;
            ce_reg       <= ce_next;
        end
    end

    `ASSERT_PROP(a_done_to_idle, clk, rst_n, step_en && done |=> phase_reg == PH_IDLE)
    `ASSERT_PROP(a_hold_when_stalled, clk, rst_n, !step_en |=> $stable(phase_reg))
    `ASSERT_PROP(a_tx_drives_ce, clk, rst_n, (phase_reg == PH_TX_LOW || phase_reg == PH_TX_HIGH) |-> (ce_reg && drv_reg))
    `ASSERT_NEVER(a_bit_cnt_range, clk, rst_n, bit_cnt_reg > WRITE_BITS)

endmodule
